@@ src/sks_pkg.sv @@
// ----------------------------------------------------------------------------
// sks_pkg
// Types and constants shared by the smoothstep keyframe sampler.
// ----------------------------------------------------------------------------
package sks_pkg;

  localparam int unsigned PoseN    = 6;
  localparam int unsigned CompW    = 16;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned FracW    = 17;
  localparam int unsigned MulW     = 19;
  localparam int unsigned KeyW     = TimeW + PoseN * CompW;
  localparam logic [TimeW-1:0] MinSpan = 16'd7;
  localparam logic [FracW-1:0] FracOne = 17'h10000;
  localparam logic [MulW-1:0]  ThreeOne = 19'd196608;

  typedef enum logic [0:0] {
    MODE_WRITE  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SCAN,
    ST_DIV,
    ST_MUL_F,
    ST_MUL_G,
    ST_LERP
  } state_e;

  typedef logic [PoseN-1:0][CompW-1:0] pose_t;

  typedef struct packed {
    mode_e             mode;
    logic [2:0]        key_index;
    logic [TimeW-1:0]  key_time;
    logic signed [15:0] key_pos_x;
    logic signed [15:0] key_pos_y;
    logic signed [15:0] key_pos_z;
    logic signed [15:0] key_rot_x;
    logic signed [15:0] key_rot_y;
    logic signed [15:0] key_rot_z;
    logic [TimeW-1:0]  sample_time;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_pos_x;
    logic signed [15:0] out_pos_y;
    logic signed [15:0] out_pos_z;
    logic signed [15:0] out_rot_x;
    logic signed [15:0] out_rot_y;
    logic signed [15:0] out_rot_z;
  } out_word_t;

endpackage

@@ src/sks_ram.sv @@
// ----------------------------------------------------------------------------
// sks_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sks_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ src/smoothstep_keyframe_sampler.sv @@
// ----------------------------------------------------------------------------
// smoothstep_keyframe_sampler
// Keyframe table with smoothstep-eased interpolation of a six-value pose.
// ----------------------------------------------------------------------------
// Usage: a word is taken on start_i while busy_o is low. A write word
// (mode 0) stores one keyframe in that same cycle and leaves busy_o low,
// so writes go at one per cycle. A sample word raises busy_o and runs a
// sequencer around one keyframe RAM read port, a one-bit-per-cycle
// restoring divider and one shared 19x19 multiplier.
// A sample clamps to the first key, else to the last key, else scans for
// the span that holds the time (giving the last key's pose if none does),
// divides unless the span is short or the time hits the upper key, and
// runs 2 ease multiplies and 6 lerp multiplies into the result. A new word
// can be taken while done_o is high. The result is shown on result_o for
// one cycle with done_o high; the receiver cannot stall. cfg_we_i writes
// key_count; the user must write it only while idle, which the block does
// not enforce. Reset sets key_count to 1 and idles the sequencer;
// the keyframe RAM is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module smoothstep_keyframe_sampler #(
  parameter int unsigned MAX_KEYS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_data_i,
  input  logic                 start_i,
  input  sks_pkg::in_word_t    in_i,
  output logic                 busy_o,
  output logic                 done_o,
  output sks_pkg::out_word_t   result_o
);

  localparam int unsigned AW = $clog2(MAX_KEYS);

  sks_pkg::state_e state_q, state_d;
  logic [3:0]      key_count_q;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   i_q, i_d;
  logic [AW-1:0]   last_idx;
  logic [sks_pkg::TimeW-1:0] t_q, t_d, prev_t_q, prev_t_d, span_q, span_d;
  sks_pkg::pose_t  a_q, a_d, b_q, b_d, res_q, res_d;
  logic [16:0]     rem_q, rem_d;
  logic [3:0]      dc_q, dc_d;
  logic [2:0]      k_q, k_d;
  logic [sks_pkg::FracW-1:0] f_q, f_d, f2_q, f2_d, sf_q, sf_d;
  logic            done_q, done_d;

  logic [sks_pkg::KeyW-1:0] wdata, rdata;
  logic [sks_pkg::TimeW-1:0] rd_t;
  sks_pkg::pose_t  rd_p;
  logic            we;
  logic [31:0]     widx;
  logic [5:0]      n_ext;

  logic signed [sks_pkg::MulW-1:0]   ma, mb;
  logic signed [2*sks_pkg::MulW-1:0] prod, adj;
  logic [16:0]     r2;
  logic [sks_pkg::TimeW-1:0] diff;

  assign widx  = 32'(in_i.key_index);
  assign we    = start_i && !busy_o && (in_i.mode == sks_pkg::MODE_WRITE)
                 && (widx < MAX_KEYS);
  assign wdata = {in_i.key_time, in_i.key_pos_x, in_i.key_pos_y, in_i.key_pos_z,
                  in_i.key_rot_x, in_i.key_rot_y, in_i.key_rot_z};
  assign rd_t  = rdata[sks_pkg::KeyW-1 -: sks_pkg::TimeW];
  assign rd_p  = rdata[sks_pkg::PoseN*sks_pkg::CompW-1:0];

  sks_ram #(
    .Width(sks_pkg::KeyW),
    .Depth(MAX_KEYS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(widx[AW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // clamp key count into 1..MAX_KEYS
  always_comb begin
    n_ext = 6'(key_count_q);
    if (n_ext == 6'd0) begin
      n_ext = 6'd1;
    end else if (32'(n_ext) > MAX_KEYS) begin
      n_ext = 6'(MAX_KEYS);
    end
    last_idx = AW'(n_ext - 6'd1);
  end

  assign prod = ma * mb;
  assign adj  = prod[2*sks_pkg::MulW-1] ? prod + 38'sd65535 : prod;
  assign r2   = {rem_q[15:0], 1'b0};
  assign diff = t_q - prev_t_q;

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    t_d      = t_q;
    prev_t_d = prev_t_q;
    span_d   = span_q;
    a_d      = a_q;
    b_d      = b_q;
    res_d    = res_q;
    rem_d    = rem_q;
    dc_d     = dc_q;
    k_d      = k_q;
    f_d      = f_q;
    f2_d     = f2_q;
    sf_d     = sf_q;
    done_d   = 1'b0;
    raddr    = '0;
    ma       = '0;
    mb       = '0;
    case (state_q)
      sks_pkg::ST_IDLE: begin
        if (start_i && in_i.mode == sks_pkg::MODE_SAMPLE) begin
          t_d     = in_i.sample_time;
          state_d = sks_pkg::ST_CHK_FIRST;
        end
      end
      sks_pkg::ST_CHK_FIRST: begin
        if (t_q <= rd_t) begin
          res_d   = rd_p;
          done_d  = 1'b1;
          state_d = sks_pkg::ST_IDLE;
        end else begin
          prev_t_d = rd_t;
          a_d      = rd_p;
          raddr    = last_idx;
          state_d  = sks_pkg::ST_CHK_LAST;
        end
      end
      sks_pkg::ST_CHK_LAST: begin
        res_d = rd_p;
        if (t_q >= rd_t) begin
          done_d  = 1'b1;
          state_d = sks_pkg::ST_IDLE;
        end else begin
          i_d     = AW'(1);
          raddr   = AW'(1);
          state_d = sks_pkg::ST_SCAN;
        end
      end
      sks_pkg::ST_SCAN: begin
        if (t_q >= prev_t_q && t_q <= rd_t) begin
          b_d    = rd_p;
          span_d = rd_t - prev_t_q;
          rem_d  = 17'(diff);
          dc_d   = '0;
          f_d    = '0;
          if (rd_t - prev_t_q < sks_pkg::MinSpan) begin
            state_d = sks_pkg::ST_MUL_F;
          end else if (diff == rd_t - prev_t_q) begin
            f_d     = sks_pkg::FracOne;
            state_d = sks_pkg::ST_MUL_F;
          end else begin
            state_d = sks_pkg::ST_DIV;
          end
        end else if (i_q == last_idx) begin
          done_d  = 1'b1;
          state_d = sks_pkg::ST_IDLE;
        end else begin
          prev_t_d = rd_t;
          a_d      = rd_p;
          i_d      = i_q + AW'(1);
          raddr    = i_q + AW'(1);
        end
      end
      sks_pkg::ST_DIV: begin
        if (r2 >= 17'(span_q)) begin
          rem_d = r2 - 17'(span_q);
          f_d   = {f_q[15:0], 1'b1};
        end else begin
          rem_d = r2;
          f_d   = {f_q[15:0], 1'b0};
        end
        dc_d = dc_q + 4'd1;
        if (dc_q == 4'd15) begin
          state_d = sks_pkg::ST_MUL_F;
        end
      end
      sks_pkg::ST_MUL_F: begin
        ma      = {2'b00, f_q};
        mb      = {2'b00, f_q};
        f2_d    = prod[32:16];
        state_d = sks_pkg::ST_MUL_G;
      end
      sks_pkg::ST_MUL_G: begin
        ma      = {2'b00, f2_q};
        mb      = sks_pkg::ThreeOne - {1'b0, f_q, 1'b0};
        sf_d    = prod[32:16];
        k_d     = '0;
        state_d = sks_pkg::ST_LERP;
      end
      sks_pkg::ST_LERP: begin
        ma = 19'(signed'(b_q[k_q])) - 19'(signed'(a_q[k_q]));
        mb = {2'b00, sf_q};
        res_d[k_q] = a_q[k_q] + adj[31:16];
        k_d = k_q + 3'd1;
        if (k_q == 3'(sks_pkg::PoseN - 1)) begin
          done_d  = 1'b1;
          state_d = sks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sks_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sks_pkg::ST_IDLE;
      key_count_q <= 4'd1;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        key_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    t_q      <= t_d;
    prev_t_q <= prev_t_d;
    span_q   <= span_d;
    a_q      <= a_d;
    b_q      <= b_d;
    res_q    <= res_d;
    rem_q    <= rem_d;
    dc_q     <= dc_d;
    k_q      <= k_d;
    f_q      <= f_d;
    f2_q     <= f2_d;
    sf_q     <= sf_d;
  end

  assign busy_o   = (state_q != sks_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = {res_q[5], res_q[4], res_q[3], res_q[2], res_q[1], res_q[0]};

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && in_i.mode == sks_pkg::MODE_SAMPLE) |=> busy_o)
    else $error("sample word not taken");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sks_pkg::ST_IDLE && !done_o) |=> !done_o)
    else $error("result without sample");
`endif

endmodule

@@ bench/sks_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sks_checker
// Watches the command and result ports of the keyframe sampler, keeps its
// own keyframe table and key count, works out the pose of every sample
// word and compares each result word, field by field, in order.
// ----------------------------------------------------------------------------
module sks_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                start_i,
  input  sks_pkg::in_word_t   in_i,
  input  logic                busy_o,
  input  logic                done_o,
  input  sks_pkg::out_word_t  result_o,
  output int                  errors_o,
  output int                  pending_o
);

  logic [15:0] key_tm [8];
  logic [95:0] key_ps [8];
  logic [3:0]  key_cnt;
  sks_pkg::out_word_t pose_q [$];

  function automatic logic [15:0] comp(logic [95:0] p, int k);
    return p[95-16*k -: 16];
  endfunction

  function automatic sks_pkg::out_word_t pose_at(logic [15:0] t);
    int          n;
    int          i;
    int          hit;
    longint      span;
    longint      f;
    longint      sf;
    longint      a;
    longint      d;
    logic [95:0] r;
    n = (key_cnt == 0) ? 1 : (key_cnt > 8) ? 8 : key_cnt;
    if (t <= key_tm[0]) return sks_pkg::out_word_t'(key_ps[0]);
    if (t >= key_tm[n-1]) return sks_pkg::out_word_t'(key_ps[n-1]);
    hit = -1;
    for (i = 0; i + 1 < n; i++) begin
      if (hit < 0 && t >= key_tm[i] && t <= key_tm[i+1]) hit = i;
    end
    if (hit < 0) return sks_pkg::out_word_t'(key_ps[n-1]);
    span = longint'(key_tm[hit+1]) - longint'(key_tm[hit]);
    f = 0;
    if (span >= 7) f = ((longint'(t) - longint'(key_tm[hit])) << 16) / span;
    sf = (((f * f) >> 16) * (3 * 65536 - 2 * f)) >> 16;
    for (int k = 0; k < 6; k++) begin
      a = longint'($signed(comp(key_ps[hit], k)));
      d = longint'($signed(comp(key_ps[hit+1], k))) - a;
      r[95-16*k -: 16] = 16'(a + (d * sf) / 65536);
    end
    return sks_pkg::out_word_t'(r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int bad;
    bad = 0;
    if (!rst_ni) begin
      key_cnt   <= 4'd1;
      errors_o  <= 0;
      pending_o <= 0;
      pose_q.delete();
    end else begin
      if (cfg_we_i) key_cnt <= cfg_data_i;
      if (start_i && !busy_o) begin
        if (in_i.mode == sks_pkg::MODE_WRITE) begin
          key_tm[in_i.key_index] <= in_i.key_time;
          key_ps[in_i.key_index] <= {in_i.key_pos_x, in_i.key_pos_y, in_i.key_pos_z,
                                     in_i.key_rot_x, in_i.key_rot_y, in_i.key_rot_z};
        end else begin
          pose_q.push_back(pose_at(in_i.sample_time));
        end
      end
      if (done_o) begin
        if (pose_q.size() == 0) begin
          $display("%0t: result word with none expected: %h", $time, result_o);
          bad = 1;
        end else begin
          for (int k = 0; k < 6; k++) begin
            if (comp(pose_q[0], k) !== comp(result_o, k)) begin
              $display("%0t: pose field %0d expected %0d actual %0d", $time, k,
                       $signed(comp(pose_q[0], k)), $signed(comp(result_o, k)));
              bad++;
            end
          end
          void'(pose_q.pop_front());
        end
      end
      if (bad != 0) errors_o <= errors_o + bad;
      pending_o <= pose_q.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the smoothstep keyframe sampler with keyframe tables and sample
// words: a directed part on range edges, clamping, short spans, key counts
// out of range and unsorted times, then random tables with random gaps.
// ----------------------------------------------------------------------------
module testbench;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_data_i;
  logic       start_i;
  sks_pkg::in_word_t  in_i;
  logic       busy_o;
  logic       done_o;
  sks_pkg::out_word_t result_o;
  int         errors;
  int         pending;
  int         words;
  int         idle_cycles;

  smoothstep_keyframe_sampler dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .start_i, .in_i,
    .busy_o, .done_o, .result_o
  );

  sks_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .start_i, .in_i,
    .busy_o, .done_o, .result_o, .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // watchdog on cycles with nothing moving
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("smoothstep_keyframe_sampler: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(sks_pkg::in_word_t w);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
          ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= w;
    do @(posedge clk_i); while (busy_o);
    words++;
    @(negedge clk_i);
  endtask

  task automatic put_key(int slot, logic [15:0] t, logic [95:0] p);
    sks_pkg::in_word_t w;
    w = sks_pkg::in_word_t'($bits(sks_pkg::in_word_t)'({$urandom, $urandom, $urandom,
                                                        $urandom, $urandom}));
    w.mode = sks_pkg::MODE_WRITE;
    w.key_index = 3'(slot);
    w.key_time = t;
    {w.key_pos_x, w.key_pos_y, w.key_pos_z, w.key_rot_x, w.key_rot_y, w.key_rot_z} = p;
    send(w);
  endtask

  task automatic sample(logic [15:0] t);
    sks_pkg::in_word_t w;
    w = sks_pkg::in_word_t'($bits(sks_pkg::in_word_t)'({$urandom, $urandom, $urandom,
                                                        $urandom, $urandom}));
    w.mode = sks_pkg::MODE_SAMPLE;
    w.sample_time = t;
    send(w);
  endtask

  task automatic rand_key(int slot, logic [15:0] t);
    put_key(slot, t, {rand_comp(), rand_comp(), rand_comp(),
                      rand_comp(), rand_comp(), rand_comp()});
  endtask

  task automatic settle_and_count(logic [3:0] n);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= n;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int          step;
    int          nk;
    int          tt;
    logic [15:0] t_lo;
    logic [15:0] t_hi;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_data_i = '0; start_i = 1'b0;
    in_i = '0; words = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: full table with edge values and a short span
    settle_and_count(4'd8);
    put_key(0, 16'd0,     {6{16'h8000}});
    put_key(1, 16'd100,   {6{16'h7fff}});
    put_key(2, 16'd103,   {6{16'h8000}});
    put_key(3, 16'd1000,  {16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h1234});
    put_key(4, 16'd30000, {16'h8000, 16'h7fff, 16'h0001, 16'h0000, 16'hffff, 16'hedcb});
    put_key(5, 16'd30007, {6{16'h0100}});
    put_key(6, 16'd60000, {6{16'hff00}});
    put_key(7, 16'd65535, {6{16'h7fff}});
    sample(16'd0); sample(16'd65535); sample(16'd50); sample(16'd101);
    sample(16'd1000); sample(16'd15000); sample(16'd30003); sample(16'd62000);
    settle_and_count(4'd0);
    sample(16'd40000);
    settle_and_count(4'd15);
    sample(16'd64000);
    // unsorted times
    put_key(3, 16'd50, {6{16'h4000}});
    settle_and_count(4'd5);
    sample(16'd500); sample(16'd20000);

    while (words < 1150) begin
      settle_and_count(($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8)));
      if ($urandom_range(0, 4) != 0) begin
        step = ($urandom_range(0, 3) == 0) ? 12 : 65535 / $urandom_range(4, 9);
        tt = $urandom_range(0, 2000);
        for (int s = 0; s < 8; s++) begin
          rand_key(s, 16'((tt > 65535) ? 65535 : tt));
          tt += $urandom_range(0, step);
        end
      end else begin
        for (int s = $urandom_range(1, 6); s > 0; s--) rand_key($urandom_range(0, 7), 16'($urandom));
      end
      nk = $urandom_range(0, 5) == 0 ? 0 : 2000;
      t_lo = 16'($urandom_range(0, nk));
      t_hi = 16'($urandom_range(0, 65535));
      for (int s = $urandom_range(8, 30); s > 0; s--) begin
        if ($urandom_range(0, 3) == 0) sample(16'($urandom));
        else if ($urandom_range(0, 9) == 0) rand_key($urandom_range(0, 7), 16'($urandom));
        else sample(16'($urandom_range(t_lo, t_lo < t_hi ? t_hi : 65535)));
      end
    end

    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (errors == 0) begin
      $display("smoothstep_keyframe_sampler: match");
    end else begin
      $display("smoothstep_keyframe_sampler: mismatch");
    end
    $finish;
  end

endmodule
